@@ rtl/lcdns_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_LIGHT = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    EV_SHIFT  = 2'd0,
    EV_LATCH  = 2'd1,
    EV_ENABLE = 2'd2
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    logic     data_bit;
    logic     last;
  } lcdns_ev_t;

  localparam logic [7:0] RS_BIT    = 8'h80;
  localparam logic [7:0] LED_BIT   = 8'h01;
  localparam logic [7:0] DATA_MASK = 8'h1E;

  localparam int unsigned CNT_W = 5;
  // events per nibble: 8 shifts, latch, enable
  localparam logic [CNT_W-1:0] NIB_EVENTS = 5'd10;
  localparam logic [CNT_W-1:0] LATCH_SLOT = 5'd8;
  localparam logic [CNT_W-1:0] LIGHT_LAST = 5'd8;
  localparam logic [CNT_W-1:0] BYTE_LAST  = 5'd19;

endpackage

`default_nettype wire

@@ rtl/lcdns_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lcdns_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [1:0]           req_type,
  input  wire logic [7:0]           req_value,
  input  wire logic                 ev_ready,
  output logic                      ev_valid,
  output lcdns_pkg::lcdns_ev_t      ev
);

  logic                         busy_r, busy_nxt;
  logic [lcdns_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                   shadow_r, shadow_nxt;
  logic [7:0]                   hi_r, hi_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic                         light_r, light_nxt;

  logic                         step;
  logic                         accept;
  logic                         second;
  logic [lcdns_pkg::CNT_W-1:0]  slot;
  logic [7:0]                   cur;
  logic [7:0]                   rs_byte;
  logic [7:0]                   hi_byte;
  logic [7:0]                   lo_byte;
  logic [7:0]                   led_byte;

  function automatic logic [7:0] place_nibble(input logic [7:0] base, input logic [3:0] nib);
    place_nibble = (base & ~lcdns_pkg::DATA_MASK) |
                   {3'b000, nib[0], nib[1], nib[2], nib[3], 1'b0};
  endfunction

  assign second = (cnt_r >= lcdns_pkg::NIB_EVENTS);
  assign slot   = second ? (cnt_r - lcdns_pkg::NIB_EVENTS) : cnt_r;
  assign cur    = second ? lo_r : hi_r;

  always_comb begin
    ev.data_bit = 1'b0;
    ev.kind     = lcdns_pkg::EV_SHIFT;
    if (slot < lcdns_pkg::LATCH_SLOT) begin
      ev.data_bit = cur[~slot[2:0]];
    end else if (slot == lcdns_pkg::LATCH_SLOT) begin
      ev.kind = lcdns_pkg::EV_LATCH;
    end else begin
      ev.kind = lcdns_pkg::EV_ENABLE;
    end
    ev.last = light_r ? (cnt_r == lcdns_pkg::LIGHT_LAST) : (cnt_r == lcdns_pkg::BYTE_LAST);
  end

  assign ev_valid  = busy_r;
  assign step      = busy_r && ev_ready;
  assign req_ready = !busy_r || (step && ev.last);
  assign accept    = req_valid && req_ready;

  assign rs_byte  = (req_type == lcdns_pkg::REQ_DATA) ? (shadow_r | lcdns_pkg::RS_BIT)
                                                      : (shadow_r & ~lcdns_pkg::RS_BIT);
  assign hi_byte  = place_nibble(rs_byte, req_value[7:4]);
  assign lo_byte  = place_nibble(hi_byte, req_value[3:0]);
  assign led_byte = (req_value == 8'd1) ? (shadow_r | lcdns_pkg::LED_BIT)
                                        : (shadow_r & ~lcdns_pkg::LED_BIT);

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    shadow_nxt = shadow_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    light_nxt  = light_r;
    if (step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (ev.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      cnt_nxt = '0;
      unique case (lcdns_pkg::req_type_t'(req_type))
        lcdns_pkg::REQ_CMD, lcdns_pkg::REQ_DATA: begin
          busy_nxt   = 1'b1;
          light_nxt  = 1'b0;
          hi_nxt     = hi_byte;
          lo_nxt     = lo_byte;
          shadow_nxt = lo_byte;
        end
        lcdns_pkg::REQ_LIGHT: begin
          busy_nxt   = 1'b1;
          light_nxt  = 1'b1;
          hi_nxt     = led_byte;
          lo_nxt     = led_byte;
          shadow_nxt = led_byte;
        end
        default: begin
          // drop unused request type
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      shadow_r <= '0;
      light_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      shadow_r <= shadow_nxt;
      light_r  <= light_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= lcdns_pkg::BYTE_LAST)
    else $error("event counter past end of byte sequence");
  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && light_r) |-> cnt_r <= lcdns_pkg::LIGHT_LAST)
    else $error("event counter past end of backlight sequence");
  a_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && req_ready) |-> (ev_ready && ev.last))
    else $error("new request taken before sequence ends");
  a_rw_low: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (shadow_r[6] == 1'b0 && shadow_r[5] == 1'b0))
    else $error("read/write or unused shadow bit set");
`endif

endmodule

`default_nettype wire

@@ rtl/lcd_nibble_shift_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// LCD 4-bit serializer over an 8-bit shift latch.
// Input stream: in_tuser = request type (0 command, 1 data, 2 backlight, 3 ignored),
// in_tdata = byte value. Output stream: one word per pin event; out_tuser is the
// event kind (0 shift, 1 latch, 2 enable), out_tdata[0] the serial data level,
// out_tlast marks the final event of a request.
// A command or data byte yields 20 events (per nibble: 8 shifts MSB first, latch,
// enable); a backlight request yields 9 events (8 shifts, latch).
// The first event passes the sequencer state register, then the output register.
// Throughput: one event per cycle from the event counter while out_tready is high;
// the next request is taken in the cycle its predecessor's last event moves to
// the output register, so requests run back to back. Type 3 is taken and dropped
// without events.
// Reset (rst_n low, synchronous) clears the shadow latch byte and the sequencer.
// When the receiver holds out_tready low, the output word and the sequencer hold,
// and in_tready stays low until the last event can advance.
module lcd_nibble_shift_serializer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] value
  input  wire logic [1:0] in_tuser,   // [1:0] req_type
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [0] data_bit, [7:1] zero
  output logic [1:0]      out_tuser,  // [1:0] event_kind
  output logic            out_tlast
);

  logic                 ev_valid;
  logic                 ev_ready;
  lcdns_pkg::lcdns_ev_t ev;
  logic                 out_valid_r, out_valid_nxt;
  lcdns_pkg::lcdns_ev_t out_ev_r, out_ev_nxt;

  lcdns_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (in_tuser),
    .req_value (in_tdata),
    .ev_ready  (ev_ready),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  assign ev_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ev_nxt    = out_ev_r;
    if (ev_ready) begin
      out_valid_nxt = ev_valid;
      out_ev_nxt    = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_ev_r <= out_ev_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ev_r.data_bit};
  assign out_tuser  = out_ev_r.kind;
  assign out_tlast  = out_ev_r.last;

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r.last) |-> out_ev_r.kind != lcdns_pkg::EV_SHIFT)
    else $error("last marker on a shift event");
  a_pulse_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r.kind != lcdns_pkg::EV_SHIFT) |-> !out_ev_r.data_bit)
    else $error("data level set on a pulse event");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lcdns_pkg::*;

  typedef struct {
    req_type_t  kind;
    logic [7:0] value;
    bit         drain;
  } lcd_req_t;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] value
  logic [1:0] in_tuser   = REQ_CMD; // [1:0] req_type
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [0] data_bit, [7:1] zero
  logic [1:0] out_tuser;            // [1:0] event_kind
  logic       out_tlast;

  lcd_req_t   req_q[$];
  lcdns_ev_t  pin_ev_q[$];
  logic [7:0] shadow_byte = 8'h00;
  int         err_cnt     = 0;
  int         cycle_cnt   = 0;
  int         burst_left  = 1;
  int         gap_left    = 0;
  logic [7:0] rdy_pattern = 8'hFF;
  int         rdy_hold    = 0;

  lcd_nibble_shift_serializer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 50) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  task automatic add_req(input req_type_t kind, input logic [7:0] value, input bit drain);
    lcd_req_t r;
    r.kind  = kind;
    r.value = value;
    r.drain = drain;
    req_q.push_back(r);
  endtask

  function automatic void push_ev(input ev_kind_t kind, input logic bit_val,
                                  input logic is_last);
    lcdns_ev_t e;
    e.kind     = kind;
    e.data_bit = bit_val;
    e.last     = is_last;
    pin_ev_q.push_back(e);
  endfunction

  // shift the shadow byte MSB first, then latch it
  function automatic void shift_out_shadow(input logic latch_last);
    for (int i = 7; i >= 0; i--) begin
      push_ev(EV_SHIFT, shadow_byte[i], 1'b0);
    end
    push_ev(EV_LATCH, 1'b0, latch_last);
  endfunction

  function automatic void predict_pin_events(input req_type_t kind, input logic [7:0] value);
    logic [3:0] nib;
    case (kind)
      REQ_CMD, REQ_DATA: begin
        shadow_byte[7] = (kind == REQ_DATA);
        for (int h = 0; h < 2; h++) begin
          nib = (h == 0) ? value[7:4] : value[3:0];
          // D4..D7 sit on bits 4..1
          shadow_byte[4:1] = {nib[0], nib[1], nib[2], nib[3]};
          shift_out_shadow(1'b0);
          push_ev(EV_ENABLE, 1'b0, h == 1);
        end
      end
      REQ_LIGHT: begin
        shadow_byte[0] = (value == 8'd1);
        shift_out_shadow(1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : drv
    lcd_req_t nxt;
    logic     take;
    take = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      predict_pin_events(req_type_t'(in_tuser), in_tdata);
    end
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0 && !(req_q[0].drain && pin_ev_q.size() != 0)) begin
        nxt = req_q.pop_front();
        take = 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= nxt.value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                 : $urandom_range(0, 4);
        end
      end
    end
    in_tvalid <= take || (rst_n && in_tvalid && !in_tready);
  end

  always @(posedge clk) begin : mon
    lcdns_ev_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_ev_q.size() == 0) begin
        report($sformatf("unexpected word kind=%0d data=%02h last=%0b",
                         out_tuser, out_tdata, out_tlast));
      end else begin
        want = pin_ev_q.pop_front();
        if (out_tuser != want.kind) begin
          report($sformatf("event_kind got %0d want %0d", out_tuser, want.kind));
        end
        if (out_tdata != {7'd0, want.data_bit}) begin
          report($sformatf("tdata got %02h want %02h", out_tdata, {7'd0, want.data_bit}));
        end
        if (out_tlast != want.last) begin
          report($sformatf("last got %0b want %0b", out_tlast, want.last));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rdy_hold == 0) begin
        case ($urandom_range(0, 3))
          0:       rdy_pattern = 8'hFF;
          1:       rdy_pattern = 8'($urandom);
          2:       rdy_pattern = 8'b0001_0001;
          default: rdy_pattern = 8'h01;
        endcase
        rdy_hold = $urandom_range(20, 80);
      end else begin
        rdy_hold--;
      end
      rdy_pattern = {rdy_pattern[6:0], rdy_pattern[7]};
      out_tready <= rdy_pattern[0];
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stim
    int        sel;
    logic [7:0] v;

    add_req(REQ_CMD,   8'h00, 1'b0);
    add_req(REQ_CMD,   8'hFF, 1'b0);
    add_req(REQ_DATA,  8'h00, 1'b0);
    add_req(REQ_DATA,  8'hFF, 1'b0);
    add_req(REQ_LIGHT, 8'h01, 1'b0);
    add_req(REQ_DATA,  8'hA5, 1'b0);
    add_req(REQ_CMD,   8'h5A, 1'b0);
    add_req(REQ_LIGHT, 8'h00, 1'b1);
    add_req(REQ_DATA,  8'h3C, 1'b0);
    add_req(REQ_LIGHT, 8'h02, 1'b0);
    add_req(REQ_LIGHT, 8'h01, 1'b0);
    add_req(REQ_NONE,  8'hFF, 1'b0);
    add_req(REQ_CMD,   8'h81, 1'b0);
    add_req(REQ_LIGHT, 8'hFF, 1'b0);
    add_req(REQ_NONE,  8'h00, 1'b0);
    add_req(REQ_DATA,  8'h7E, 1'b0);
    add_req(REQ_LIGHT, 8'h81, 1'b0);
    add_req(REQ_LIGHT, 8'h01, 1'b1);
    add_req(REQ_CMD,   8'h0F, 1'b0);
    add_req(REQ_DATA,  8'hF0, 1'b0);
    add_req(REQ_NONE,  8'h01, 1'b0);
    add_req(REQ_LIGHT, 8'h00, 1'b0);

    for (int k = 0; k < 260; k++) begin
      sel = $urandom_range(0, 99);
      v   = 8'($urandom_range(0, 255));
      if (sel < 40) begin
        add_req(REQ_CMD, v, $urandom_range(0, 49) == 0);
      end else if (sel < 80) begin
        add_req(REQ_DATA, v, $urandom_range(0, 49) == 0);
      end else if (sel < 95) begin
        add_req(REQ_LIGHT, ($urandom_range(0, 1) == 0) ? 8'h01 : v,
                $urandom_range(0, 49) == 0);
      end else begin
        add_req(REQ_NONE, v, 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pin_ev_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
